// ===== hdl/iirbp_pkg.sv =====
// Shared types and defaults for the multichannel IIR bandpass filter.
// Transfer payload structs, command codes, sequencer states.
// No dependencies.
`default_nettype none

package iirbp_pkg;

   // Default sizes for the top-level parameters
   localparam int CHANNELS_DEF       = 16;
   localparam int HALF_ORDER_DEF     = 5;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_BITS_DEF      = 32;
   localparam int COEF_FRAC_BITS_DEF = 22;

   // Accumulator wraps modulo 2^64
   localparam int ACC_BITS = 64;

   // Command codes
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_LOAD_A = 2'd2;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [3:0]          channel;
      logic                start_req;
      logic signed [23:0]  sample;
      logic [3:0]          coef_index;
      logic signed [31:0]  coef_value;
   } req_type;

   typedef struct packed {
      logic [3:0]          out_channel;
      logic signed [23:0]  filtered;
      logic                saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_ACC,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/multichannel_iir_bandpass_filter.sv =====
// Multichannel direct form I IIR filter, top level.
// Depends on iirbp_pkg (payload structs, command codes, state enum).
//  - req channel (valid/ready): one transfer carries a command. CMD_LOAD_B / CMD_LOAD_A
//    write one shared numerator / denominator coefficient (Q10.22, a0 fixed at 1);
//    CMD_SAMPLE filters one sample of one channel. Unknown commands, channels out of
//    range and bad coefficient indexes are dropped without a result.
//  - rsp channel (valid/ready): one transfer per accepted sample: channel, saturated
//    output and a clip flag.
//  - Timing: a load is written straight into the coefficient registers. A sample with F
//    past samples in its channel history (F = 0..2*HALF_ORDER) occupies the block from
//    accept to the next possible accept: 2*F + 1 multiplies on the single shared
//    multiplier (ST_RUN), a drain of the product register into the accumulator (ST_ACC),
//    round, saturate and write back (ST_FIN), then ST_IDLE to accept the next request.
//    The result is loaded into the output register by the write-back step.
//  - Histories live in two synchronous RAMs (x and y), a ring of 2*HALF_ORDER entries
//    per channel, read one tap at a time and written once at the end.
//  - A start flag empties the channel history; unfilled taps count as zero. Reset clears
//    coefficients, fill counts and pointers; RAMs need no clearing pass.
//  - Receiver stall: the result waits in the output register while the next sample
//    runs; that sample then holds in its final cycle until the register frees up.
`default_nettype none

module multichannel_iir_bandpass_filter #(
   parameter int CHANNELS       = iirbp_pkg::CHANNELS_DEF,
   parameter int HALF_ORDER     = iirbp_pkg::HALF_ORDER_DEF,
   parameter int SAMPLE_BITS    = iirbp_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS      = iirbp_pkg::COEF_BITS_DEF,
   parameter int COEF_FRAC_BITS = iirbp_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire iirbp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output iirbp_pkg::rsp_type     rsp_data
);

   import iirbp_pkg::*;

   localparam int TAPS   = 2 * HALF_ORDER;
   localparam int DEPTH  = CHANNELS * TAPS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FILL_W = $clog2(TAPS + 1);
   localparam int PTR_W  = $clog2(TAPS);
   localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   // shared coefficients, reset to zero; a_ff[k-1] holds a[k]
   logic signed [COEF_BITS-1:0]   b_ff [TAPS+1];
   logic signed [COEF_BITS-1:0]   a_ff [TAPS];

   // per-channel ring control
   logic [FILL_W-1:0]             fill_ff [CHANNELS];
   logic [PTR_W-1:0]              ptr_ff  [CHANNELS];

   // history RAMs
   logic signed [SAMPLE_BITS-1:0] x_mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] y_mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] x_rd_ff, y_rd_ff;

   // per-item working registers
   logic [CH_W-1:0]               ch_ff;
   logic [ADDR_W-1:0]             base_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [FILL_W-1:0]             fill_cur_ff;
   logic [PTR_W-1:0]              rd_ptr_ff;
   logic [FILL_W-1:0]             tap_ff;
   logic                          ph_ff;     // 0: b*x phase, 1: a*y phase

   // multiply / accumulate pipe
   logic signed [PROD_W-1:0]      mul_ff, mul_in;
   logic                          mv_ff;
   logic                          msub_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;

   // output register
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   // ---------------------------------------------------------------- decode
   logic              req_fire, ch_ok, sample_go, load_b_go, load_a_go;
   logic [CH_W-1:0]   req_ch;

   assign req_fire  = req_valid && req_ready;
   assign ch_ok     = 32'(req_data.channel) < CHANNELS;
   assign req_ch    = CH_W'(req_data.channel);
   assign sample_go = req_fire && (req_data.cmd == CMD_SAMPLE) && ch_ok;
   assign load_b_go = req_fire && (req_data.cmd == CMD_LOAD_B)
                      && (32'(req_data.coef_index) <= TAPS);
   assign load_a_go = req_fire && (req_data.cmd == CMD_LOAD_A)
                      && (req_data.coef_index != 4'd0)
                      && (32'(req_data.coef_index) <= TAPS);

   // ---------------------------------------------------------------- sequencer
   logic last_op, out_free;
   logic run_en, rd_en, fin_go;

   // last multiply: b0 alone when history is empty, else the a-phase of tap F
   assign last_op  = (tap_ff == fill_cur_ff) && ((tap_ff == '0) || ph_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_go) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last_op) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      run_en    = (state_ff == ST_RUN);
      // fetch next tap after b0 and after each a-phase
      rd_en     = run_en && ((tap_ff == '0) || ph_ff);
      fin_go    = (state_ff == ST_FIN) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         ph_ff    <= 1'b0;
         mv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         mv_ff    <= run_en;
         if (sample_go) begin
            tap_ff <= '0;
            ph_ff  <= 1'b0;
         end else if (run_en && !last_op) begin
            if (tap_ff == '0) begin
               tap_ff <= FILL_W'(1);
               ph_ff  <= 1'b0;
            end else if (!ph_ff) begin
               ph_ff <= 1'b1;
            end else begin
               ph_ff  <= 1'b0;
               tap_ff <= tap_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS + 1; i++) b_ff[i] <= '0;
         for (int i = 0; i < TAPS; i++)     a_ff[i] <= '0;
      end else begin
         if (load_b_go)
            b_ff[FILL_W'(req_data.coef_index)] <= COEF_BITS'(req_data.coef_value);
         if (load_a_go)
            a_ff[PTR_W'(req_data.coef_index - 4'd1)] <= COEF_BITS'(req_data.coef_value);
      end
   end

   // ---------------------------------------------------------------- ring pointers
   logic [PTR_W-1:0]  wr_ptr;
   logic [FILL_W-1:0] fill_next;
   logic [ADDR_W-1:0] rd_addr, wr_addr;

   assign wr_ptr    = (ptr_ff[ch_ff] == PTR_W'(TAPS - 1)) ? '0 : ptr_ff[ch_ff] + 1'b1;
   assign fill_next = (32'(fill_cur_ff) < TAPS) ? fill_cur_ff + 1'b1 : fill_cur_ff;
   assign rd_addr   = base_ff + ADDR_W'(rd_ptr_ff);
   assign wr_addr   = base_ff + ADDR_W'(wr_ptr);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
            ptr_ff[i]  <= '0;
         end
      end else if (fin_go) begin
         fill_ff[ch_ff] <= fill_next;
         ptr_ff[ch_ff]  <= wr_ptr;
      end
   end

   // per-item capture and ring walk, newest entry first
   always_ff @(posedge clock) begin
      if (sample_go) begin
         ch_ff       <= req_ch;
         base_ff     <= ADDR_W'(req_ch) * ADDR_W'(TAPS);
         x_ff        <= SAMPLE_BITS'(req_data.sample);
         fill_cur_ff <= req_data.start_req ? '0 : fill_ff[req_ch];
         rd_ptr_ff   <= ptr_ff[req_ch];
      end else if (rd_en) begin
         rd_ptr_ff <= (rd_ptr_ff == '0) ? PTR_W'(TAPS - 1) : rd_ptr_ff - 1'b1;
      end
   end

   // ---------------------------------------------------------------- history RAMs
   logic signed [SAMPLE_BITS-1:0] y_sat;

   always_ff @(posedge clock) begin
      if (fin_go) begin
         x_mem[wr_addr] <= x_ff;
         y_mem[wr_addr] <= y_sat;
      end
      if (rd_en) begin
         x_rd_ff <= x_mem[rd_addr];
         y_rd_ff <= y_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- MAC
   logic signed [COEF_BITS-1:0]   coef_sel;
   logic signed [SAMPLE_BITS-1:0] data_sel;
   logic                          sub_sel;

   always_comb begin
      if (tap_ff == '0) begin
         coef_sel = b_ff[0];
         data_sel = x_ff;
         sub_sel  = 1'b0;
      end else if (!ph_ff) begin
         coef_sel = b_ff[tap_ff];
         data_sel = x_rd_ff;
         sub_sel  = 1'b0;
      end else begin
         coef_sel = a_ff[PTR_W'(tap_ff - 1'b1)];
         data_sel = y_rd_ff;
         sub_sel  = 1'b1;
      end
      mul_in = coef_sel * data_sel;
   end

   logic signed [ACC_BITS-1:0] prod_ext;
   assign prod_ext = ACC_BITS'(mul_ff);

   always_ff @(posedge clock) begin
      mul_ff  <= mul_in;
      msub_ff <= sub_sel;
      if (sample_go)
         acc_ff <= '0;
      else if (mv_ff)
         acc_ff <= msub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
   end

   // ---------------------------------------------------------------- round, clip
   logic signed [ACC_BITS-1:0]           acc_rnd, acc_sh;
   logic [ACC_BITS-SAMPLE_BITS:0]        acc_hi;
   logic                                 clip_pos, clip_neg;

   assign acc_rnd  = acc_ff + (ACC_BITS'(1) << (COEF_FRAC_BITS - 1));
   assign acc_sh   = acc_rnd >>> COEF_FRAC_BITS;
   assign acc_hi   = acc_sh[ACC_BITS-1:SAMPLE_BITS-1];
   assign clip_pos = !acc_hi[ACC_BITS-SAMPLE_BITS] && (|acc_hi);
   assign clip_neg = acc_hi[ACC_BITS-SAMPLE_BITS] && !(&acc_hi);

   always_comb begin
      if (clip_pos)
         y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else if (clip_neg)
         y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else
         y_sat = acc_sh[SAMPLE_BITS-1:0];
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (fin_go)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_data_ff.out_channel <= 4'(ch_ff);
         rsp_data_ff.filtered    <= 24'(y_sat);
         rsp_data_ff.saturated   <= clip_pos || clip_neg;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (tap_ff <= fill_cur_ff))
      else $error("tap counter ran past channel fill");

   a_mac_after_run: assert property (@(posedge clock) disable iff (reset)
      mv_ff |-> $past(state_ff == ST_RUN))
      else $error("product accumulated outside the multiply run");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised without a finishing step");

endmodule

`default_nettype wire
